/* src/mhpq_pkg.sv */
// Shared types and constants for the min-heap priority queue.
`default_nettype none

package mhpq_pkg;

  // Number of entries the heap can hold.
  localparam int CAPACITY = 64;
  localparam int KEY_W    = 32;
  localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  // Child index width: 2*pos+2 must fit without wrapping.
  localparam int IDX_W    = ADDR_W + 2;

  typedef logic signed [KEY_W-1:0] key_t;
  typedef logic [ADDR_W-1:0]       addr_t;
  typedef logic [CNT_W-1:0]        cnt_t;
  typedef logic [IDX_W-1:0]        idx_t;

  // Command codes on the action port.
  localparam logic ACT_INSERT  = 1'b0;
  localparam logic ACT_EXTRACT = 1'b1;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  // Operation handed from the front end to the sift engine.
  typedef struct packed {
    logic extract;
    key_t key;
    cnt_t count;
  } op_t;

  // Completion reported by the sift engine.
  typedef struct packed {
    logic done;
    key_t min_key;
  } resp_t;

  // Child selection for one sift-down level.
  typedef struct packed {
    logic move;
    logic pick_right;
    key_t key;
  } sel_t;

endpackage

`default_nettype wire

/* src/mhpq_sel.sv */
// Sift-down child selection: picks the smallest of hole key and valid children.
`default_nettype none

module mhpq_sel (
  input  wire mhpq_pkg::key_t hole,
  input  wire mhpq_pkg::key_t left,
  input  wire mhpq_pkg::key_t right,
  input  wire                 left_ok,
  input  wire                 right_ok,
  output mhpq_pkg::sel_t      sel
);
  import mhpq_pkg::*;

  // Strict compares: the left child wins a tie with the right, the hole wins any tie.
  always_comb begin
    sel.move       = 1'b0;
    sel.pick_right = 1'b0;
    sel.key        = hole;
    if (left_ok && (left < hole)) begin
      sel.move = 1'b1;
      sel.key  = left;
    end
    if (right_ok && (right < sel.key)) begin
      sel.move       = 1'b1;
      sel.pick_right = 1'b1;
      sel.key        = right;
    end
  end

endmodule

`default_nettype wire

/* src/mhpq_engine.sv */
// Heap store and sift sequencer: read, compare, write back one level at a time.
`default_nettype none

module mhpq_engine (
  input  wire             clk,
  input  wire             rst,
  input  wire             go,
  input  wire mhpq_pkg::op_t op,
  output mhpq_pkg::resp_t resp
);
  import mhpq_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_UP_RD   = 7'b0000010,
    S_UP_CMP  = 7'b0000100,
    S_DN_LOAD = 7'b0001000,
    S_DN_RD   = 7'b0010000,
    S_DN_CMP  = 7'b0100000,
    S_SPARE   = 7'b1000000
  } state_t;

  state_t state, state_next;
  addr_t  pos, pos_next;
  key_t   hole, hole_next;
  key_t   min_key, min_next;
  cnt_t   n, n_next;

  // Heap store: one write port, two registered read ports.
  key_t   mem [CAPACITY];
  logic   we;
  addr_t  waddr;
  key_t   wdata;
  addr_t  raddr_a, raddr_b;
  key_t   rdata_a, rdata_b;

  addr_t  parent;
  idx_t   lc_idx, rc_idx;
  logic   left_ok, right_ok;
  sel_t   sel;
  logic   done;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

  // Tree neighbors of the current hole position.
  assign parent   = addr_t'((pos - addr_t'(1)) >> 1);
  assign lc_idx   = (idx_t'(pos) << 1) + idx_t'(1);
  assign rc_idx   = (idx_t'(pos) << 1) + idx_t'(2);
  assign left_ok  = lc_idx < idx_t'(n);
  assign right_ok = rc_idx < idx_t'(n);

  mhpq_sel u_sel (
    .hole     (hole),
    .left     (rdata_a),
    .right    (rdata_b),
    .left_ok  (left_ok),
    .right_ok (right_ok),
    .sel      (sel)
  );

  // Sequence the sift; the moving key stays in hole until its slot is found.
  always_comb begin
    state_next = state;
    pos_next   = pos;
    hole_next  = hole;
    min_next   = min_key;
    n_next     = n;
    we         = 1'b0;
    waddr      = pos;
    wdata      = hole;
    raddr_a    = parent;
    raddr_b    = addr_t'(rc_idx);
    done       = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (go) begin
          if (op.extract) begin
            raddr_a    = '0;
            raddr_b    = addr_t'(op.count - cnt_t'(1));
            n_next     = op.count - cnt_t'(1);
            state_next = S_DN_LOAD;
          end else begin
            pos_next   = addr_t'(op.count);
            hole_next  = op.key;
            state_next = S_UP_RD;
          end
        end
      end
      S_UP_RD: begin
        if (pos == '0) begin
          we         = 1'b1;
          done       = 1'b1;
          state_next = S_IDLE;
        end else begin
          raddr_a    = parent;
          state_next = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        we = 1'b1;
        if (rdata_a > hole) begin
          wdata      = rdata_a;
          pos_next   = parent;
          state_next = S_UP_RD;
        end else begin
          done       = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_DN_LOAD: begin
        min_next  = rdata_a;
        hole_next = rdata_b;
        pos_next  = '0;
        if (n == '0) begin
          done       = 1'b1;
          state_next = S_IDLE;
        end else begin
          raddr_a    = addr_t'(1);
          raddr_b    = addr_t'(idx_t'(2));
          state_next = S_DN_CMP;
        end
      end
      S_DN_RD: begin
        raddr_a    = addr_t'(lc_idx);
        raddr_b    = addr_t'(rc_idx);
        state_next = S_DN_CMP;
      end
      S_DN_CMP: begin
        we = 1'b1;
        if (sel.move) begin
          wdata      = sel.key;
          pos_next   = sel.pick_right ? addr_t'(rc_idx) : addr_t'(lc_idx);
          state_next = S_DN_RD;
        end else begin
          done       = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    pos     <= pos_next;
    hole    <= hole_next;
    min_key <= min_next;
    n       <= n_next;
  end

  assign resp.done    = done;
  assign resp.min_key = min_next;

`ifndef ASSERT_OFF
  a_up_not_root: assert property (@(posedge clk) disable iff (rst)
    state == S_UP_CMP |-> pos != '0)
    else $error("sift-up compare at root");
  a_dn_in_heap: assert property (@(posedge clk) disable iff (rst)
    state == S_DN_CMP |-> cnt_t'(pos) < n)
    else $error("sift-down hole outside heap");
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |=> state == S_IDLE)
    else $error("engine not idle after completion");
`endif

endmodule

`default_nettype wire

/* src/min_heap_priority_queue_top.sv */
// Top level of the min-heap priority queue: command front end and result register.
`default_nettype none

// Binary min-heap of up to 64 signed 32-bit keys. Pulse start with action
// (0 insert key_in, 1 extract minimum) while busy is low; the result appears
// on status, key_out and count_out for exactly one cycle with done high and
// must be taken then. Overflow and underflow answer in the cycle after the
// command. An insert walks up L levels, L (0 to 6) being the number of levels
// the key rises, and an extract walks down L levels, L (0 to 5) being the
// levels the moved key sinks; removing the last entry needs no sift. Each
// level takes a read step and a compare-and-write step on the single-write
// heap memory. busy drops in the cycle done rises, so the next command can be
// given while the result shows.

module min_heap_priority_queue_top (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        start,
  output logic                       busy,
  input  wire                        action,
  input  wire mhpq_pkg::key_t        key_in,
  output logic                       done,
  output logic [1:0]                 status,
  output mhpq_pkg::key_t             key_out,
  output mhpq_pkg::cnt_t             count_out
);
  import mhpq_pkg::*;

  cnt_t    count;
  logic    op_insert;
  key_t    op_key;
  logic    accept, is_full, is_empty, err, go;
  op_t     op;
  resp_t   resp;

  // Decode the command transfer and its error cases.
  assign accept   = start && !busy;
  assign is_full  = count == cnt_t'(CAPACITY);
  assign is_empty = count == '0;
  assign err      = (action == ACT_INSERT) ? is_full : is_empty;
  assign go       = accept && !err;

  assign op.extract = action == ACT_EXTRACT;
  assign op.key     = key_in;
  assign op.count   = count;

  mhpq_engine u_engine (
    .clk  (clk),
    .rst  (rst),
    .go   (go),
    .op   (op),
    .resp (resp)
  );

  // Track busy, entry count and the result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= (accept && err) || resp.done;
      if (go) begin
        busy  <= 1'b1;
        count <= (action == ACT_INSERT) ? count + cnt_t'(1) : count - cnt_t'(1);
      end
      if (resp.done) begin
        busy <= 1'b0;
      end
    end
  end

  // Hold the command payload and load the result fields.
  always_ff @(posedge clk) begin
    if (go) begin
      op_insert <= action == ACT_INSERT;
      op_key    <= key_in;
    end
    if (accept && err) begin
      status    <= (action == ACT_INSERT) ? ST_OVERFLOW : ST_UNDERFLOW;
      key_out   <= '0;
      count_out <= count;
    end
    if (resp.done) begin
      status    <= ST_OK;
      key_out   <= op_insert ? op_key : resp.min_key;
      count_out <= count;
    end
  end

`ifndef ASSERT_OFF
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    resp.done |-> busy)
    else $error("engine completion without a pending command");
  a_count_match: assert property (@(posedge clk) disable iff (rst)
    done |-> count_out == count)
    else $error("reported count differs from held count");
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= cnt_t'(CAPACITY))
    else $error("entry count above capacity");
`endif

endmodule

`default_nettype wire

/* test/tb.sv */
// Self-checking testbench for the min-heap priority queue: table-driven and random commands.
`default_nettype none

module tb;
  import mhpq_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 20;

  // One expected result of a command.
  typedef struct packed {
    status_t    st;
    key_t       key;
    logic [6:0] cnt;
  } heap_result_t;

  // One row of the directed table; expected fields count only when typed is set.
  typedef struct packed {
    logic         act;
    key_t         key;
    logic         typed;
    heap_result_t res;
  } stim_row_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              action = ACT_INSERT;
  logic signed [31:0] key_in = '0;
  logic              busy;
  logic              done;
  logic [1:0]        status;
  logic signed [31:0] key_out;
  logic [6:0]        count_out;

  // Shadow copy of the heap used to predict results.
  key_t         heap_shadow [CAPACITY];
  int           heap_size = 0;
  heap_result_t pending_q [$];
  stim_row_t    dir_rows [$];
  int           fail_count = 0;
  int           cycle_count = 0;

  min_heap_priority_queue_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .action    (action),
    .key_in    (key_in),
    .done      (done),
    .status    (status),
    .key_out   (key_out),
    .count_out (count_out)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Apply one command to the shadow heap and return the result it gives.
  function automatic heap_result_t heap_apply(input logic act, input key_t k);
    heap_result_t r;
    int           pos;
    int           up;
    int           best;
    int           lc;
    int           rc;
    key_t         t;
    r.st  = ST_OK;
    r.key = '0;
    if (act == ACT_INSERT) begin
      if (heap_size >= CAPACITY) begin
        r.st = ST_OVERFLOW;
      end else begin
        heap_shadow[heap_size] = k;
        heap_size++;
        pos = heap_size - 1;
        // sift up while the parent is strictly larger
        while (pos > 0) begin
          up = (pos - 1) / 2;
          if (heap_shadow[up] <= heap_shadow[pos]) break;
          t = heap_shadow[up];
          heap_shadow[up] = heap_shadow[pos];
          heap_shadow[pos] = t;
          pos = up;
        end
        r.key = k;
      end
    end else begin
      if (heap_size == 0) begin
        r.st = ST_UNDERFLOW;
      end else begin
        r.key = heap_shadow[0];
        heap_shadow[0] = heap_shadow[heap_size - 1];
        heap_size--;
        pos = 0;
        // sift down toward the smaller child, left on a tie
        while (heap_size > 0) begin
          best = pos;
          lc = 2 * pos + 1;
          rc = 2 * pos + 2;
          if (lc < heap_size && heap_shadow[lc] < heap_shadow[best]) best = lc;
          if (rc < heap_size && heap_shadow[rc] < heap_shadow[best]) best = rc;
          if (best == pos) break;
          t = heap_shadow[pos];
          heap_shadow[pos] = heap_shadow[best];
          heap_shadow[best] = t;
          pos = best;
        end
      end
    end
    r.cnt = heap_size[6:0];
    return r;
  endfunction

  // Mix of full-range keys, a narrow band with many duplicates, and extremes.
  function automatic key_t pick_key();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 5) return key_t'($urandom);
    if (r < 8) return key_t'($signed($urandom_range(0, 15)) - 8);
    case ($urandom_range(0, 3))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return 32'sh0;
      default: return -32'sh1;
    endcase
  endfunction

  // Mostly back-to-back or short gaps, now and then a long one.
  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Hold a command until it transfers, then record its expected result.
  task automatic send_cmd(input logic act, input key_t k, input logic typed,
                          input heap_result_t typed_res);
    heap_result_t pred;
    start  <= 1'b1;
    action <= act;
    key_in <= k;
    do @(posedge clk); while (busy !== 1'b0);
    pred = heap_apply(act, k);
    pending_q.push_back(typed ? typed_res : pred);
  endtask

  task automatic idle_for(input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Check each result against the oldest expectation.
  always @(posedge clk) begin
    heap_result_t e;
    if (!rst && done === 1'b1) begin
      if (pending_q.size() == 0) begin
        $display("%0t: result with none expected: status %0d key %0d count %0d",
                 $time, status, key_out, count_out);
        fail_count++;
      end else begin
        e = pending_q.pop_front();
        if (status !== e.st) begin
          $display("%0t: status expected %0d actual %0d", $time, e.st, status);
          fail_count++;
        end
        if (key_out !== e.key) begin
          $display("%0t: key_out expected %0d actual %0d", $time, e.key, key_out);
          fail_count++;
        end
        if (count_out !== e.cnt) begin
          $display("%0t: count_out expected %0d actual %0d", $time, e.cnt, count_out);
          fail_count++;
        end
      end
    end
  end

  // Guard against a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    int           insert_pct [6] = '{95, 10, 50, 95, 30, 60};
    int           seg_len [6]    = '{100, 100, 80, 60, 60, 50};
    heap_result_t none;
    logic         act;
    none = '{ST_OK, 32'sh0, 7'd0};

    // Directed table: extremes, duplicates, empty heap, drain to empty.
    dir_rows.push_back('{ACT_EXTRACT, 32'sh0,        1'b1, '{ST_UNDERFLOW, 32'sh0, 7'd0}});
    dir_rows.push_back('{ACT_INSERT,  32'sh7fffffff, 1'b1, '{ST_OK, 32'sh7fffffff, 7'd1}});
    dir_rows.push_back('{ACT_INSERT,  32'sh80000000, 1'b1, '{ST_OK, 32'sh80000000, 7'd2}});
    dir_rows.push_back('{ACT_INSERT,  32'sh0,        1'b0, none});
    dir_rows.push_back('{ACT_INSERT,  -32'sh1,       1'b0, none});
    dir_rows.push_back('{ACT_INSERT,  32'sh5,        1'b0, none});
    dir_rows.push_back('{ACT_INSERT,  32'sh5,        1'b0, none});
    dir_rows.push_back('{ACT_INSERT,  32'sh3,        1'b0, none});
    dir_rows.push_back('{ACT_INSERT,  -32'sh7,       1'b0, none});
    dir_rows.push_back('{ACT_INSERT,  32'sh5,        1'b0, none});
    dir_rows.push_back('{ACT_EXTRACT, 32'sh0,        1'b1, '{ST_OK, 32'sh80000000, 7'd8}});
    dir_rows.push_back('{ACT_EXTRACT, -32'sh1,       1'b0, none});
    repeat (6) dir_rows.push_back('{ACT_EXTRACT, 32'sh55aa55aa, 1'b0, none});
    dir_rows.push_back('{ACT_EXTRACT, 32'sh0,        1'b1, '{ST_OK, 32'sh7fffffff, 7'd0}});
    dir_rows.push_back('{ACT_EXTRACT, 32'sh0,        1'b1, '{ST_UNDERFLOW, 32'sh0, 7'd0}});
    dir_rows.push_back('{ACT_INSERT,  32'sh1,        1'b0, none});
    dir_rows.push_back('{ACT_EXTRACT, 32'sh0,        1'b0, none});

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      send_cmd(dir_rows[i].act, dir_rows[i].key, dir_rows[i].typed, dir_rows[i].res);
      idle_for(pick_gap());
    end

    // Random segments that swing between filling up and draining out.
    for (int s = 0; s < 6; s++) begin
      // hold off until every outstanding result has come back
      start <= 1'b0;
      while (pending_q.size() != 0) @(posedge clk);
      for (int n = 0; n < seg_len[s]; n++) begin
        act = ($urandom_range(0, 99) < insert_pct[s]) ? ACT_INSERT : ACT_EXTRACT;
        send_cmd(act, pick_key(), 1'b0, none);
        // one segment runs with no idling at all
        if (s != 2) idle_for(pick_gap());
      end
    end

    start <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
